### hw/rtl/smdu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smdu_pkg
// shared types and constants of the simd multiply/divide unit
// ----------------------------------------------------------------------------
package smdu_pkg;

  localparam int unsigned WordsPerQuad = 4;
  localparam int unsigned InTdataW     = 264;
  localparam int unsigned OutTdataW    = 392;

  typedef enum logic [3:0] {
    OP_MULT    = 4'd0,
    OP_MULTU   = 4'd1,
    OP_DIV     = 4'd2,
    OP_DIVU    = 4'd3,
    OP_PMULTH  = 4'd4,
    OP_PMULTW  = 4'd5,
    OP_PMULTUW = 4'd6,
    OP_PDIVW   = 4'd7,
    OP_PDIVUW  = 4'd8,
    OP_PDIVBW  = 4'd9
  } op_e;

  // request to an arithmetic unit
  typedef struct packed {
    logic        start;
    logic        sgn;
    logic [31:0] a;
    logic [31:0] b;
  } req_t;

  // response: multiplier gives the product, divider gives {remainder, quotient}
  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } rsp_t;

endpackage

### hw/rtl/simd_integer_mult_div_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// simd_integer_mult_div_unit
// each beat runs one step per lane, through the ISSUE and WAIT states
//   (multiply on smdu_mul, divide on the 32-step shared divider smdu_div)
// a new beat is taken only in IDLE, once the previous one reaches the output
// reset clears LO/HI to zero and empties the output register
// ----------------------------------------------------------------------------
module simd_integer_mult_div_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // opcode, src_a_low, src_a_high, src_b_low, src_b_high
  input  logic [smdu_pkg::InTdataW-1:0]  s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // dest_low, dest_high, dest_write_mask, lo_out_low, lo_out_high,
  // hi_out_low, hi_out_high
  output logic [smdu_pkg::OutTdataW-1:0] m_axis_tdata_o
);

  localparam int unsigned OutW = smdu_pkg::OutTdataW;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_WAIT  = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  state_e          state_q;
  smdu_pkg::op_e   op_q;
  logic [127:0]    a_q, b_q, lo_q, hi_q, dst_q;
  logic [1:0]      mask_q;
  logic [2:0]      cnt_q, last_q;
  logic            out_valid_q;
  logic [OutW-1:0] out_q;

  smdu_pkg::op_e   in_op;
  logic            is_div, sgn, valid_op;
  logic [2:0]      in_last;
  logic [31:0]     op_a, op_b;
  smdu_pkg::req_t  mreq, dreq;
  smdu_pkg::rsp_t  mrsp, drsp, rsp;
  logic [31:0]     prlo, prhi;
  logic [1:0]      slot;

  assign in_op = smdu_pkg::op_e'(s_axis_tdata_i[3:0]);

  always_comb begin
    valid_op = 1'b1;
    in_last  = 3'd0;
    case (in_op)
      smdu_pkg::OP_MULT, smdu_pkg::OP_MULTU,
      smdu_pkg::OP_DIV, smdu_pkg::OP_DIVU:        in_last = 3'd0;
      smdu_pkg::OP_PMULTH:                        in_last = 3'd7;
      smdu_pkg::OP_PMULTW, smdu_pkg::OP_PMULTUW,
      smdu_pkg::OP_PDIVW, smdu_pkg::OP_PDIVUW:    in_last = 3'd1;
      smdu_pkg::OP_PDIVBW:                        in_last = 3'd3;
      default:                                    valid_op = 1'b0;
    endcase
  end

  // operand select for the current step
  always_comb begin
    is_div = 1'b0;
    sgn    = 1'b0;
    op_a   = a_q[31:0];
    op_b   = b_q[31:0];
    case (op_q)
      smdu_pkg::OP_MULT: sgn = 1'b1;
      smdu_pkg::OP_MULTU: sgn = 1'b0;
      smdu_pkg::OP_DIV: begin
        is_div = 1'b1;
        sgn    = 1'b1;
      end
      smdu_pkg::OP_DIVU: is_div = 1'b1;
      smdu_pkg::OP_PMULTH: begin
        sgn  = 1'b1;
        op_a = {{16{a_q[16*cnt_q+15]}}, a_q[16*cnt_q +: 16]};
        op_b = {{16{b_q[16*cnt_q+15]}}, b_q[16*cnt_q +: 16]};
      end
      smdu_pkg::OP_PMULTW, smdu_pkg::OP_PMULTUW: begin
        sgn  = (op_q == smdu_pkg::OP_PMULTW);
        op_a = a_q[64*cnt_q[0] +: 32];
        op_b = b_q[64*cnt_q[0] +: 32];
      end
      smdu_pkg::OP_PDIVW, smdu_pkg::OP_PDIVUW: begin
        is_div = 1'b1;
        sgn    = (op_q == smdu_pkg::OP_PDIVW);
        op_a   = a_q[64*cnt_q[0] +: 32];
        op_b   = b_q[64*cnt_q[0] +: 32];
      end
      smdu_pkg::OP_PDIVBW: begin
        is_div = 1'b1;
        sgn    = 1'b1;
        op_a   = a_q[32*cnt_q[1:0] +: 32];
        op_b   = {{16{b_q[15]}}, b_q[15:0]};
      end
      default: ;
    endcase
  end

  assign mreq.start = (state_q == S_ISSUE) && !is_div;
  assign mreq.sgn   = sgn;
  assign mreq.a     = op_a;
  assign mreq.b     = op_b;
  assign dreq.start = (state_q == S_ISSUE) && is_div;
  assign dreq.sgn   = sgn;
  assign dreq.a     = op_a;
  assign dreq.b     = op_b;

  smdu_mul u_mul (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(mreq), .rsp_o(mrsp));
  smdu_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(dreq), .rsp_o(drsp));

  assign rsp  = is_div ? drsp : mrsp;
  assign prlo = rsp.res[31:0];
  assign prhi = rsp.res[63:32];
  assign slot = {cnt_q[2], cnt_q[0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_DONE && (!out_valid_q || m_axis_tready_i)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid_i) begin
            cnt_q   <= '0;
            state_q <= valid_op ? S_ISSUE : S_DONE;
          end
        end
        S_ISSUE: state_q <= S_WAIT;
        S_WAIT: begin
          if (rsp.done) begin
            case (op_q)
              smdu_pkg::OP_MULT, smdu_pkg::OP_MULTU: begin
                lo_q[63:0] <= {{32{prlo[31]}}, prlo};
                hi_q[63:0] <= {{32{prhi[31]}}, prhi};
              end
              smdu_pkg::OP_PMULTH: begin
                if (!cnt_q[1]) begin
                  lo_q[32*slot +: 32] <= prlo;
                end else begin
                  hi_q[32*slot +: 32] <= prlo;
                end
              end
              smdu_pkg::OP_PMULTW, smdu_pkg::OP_PMULTUW: begin
                lo_q[64*cnt_q[0] +: 64] <= {{32{prlo[31]}}, prlo};
                hi_q[64*cnt_q[0] +: 64] <= {{32{prhi[31]}}, prhi};
              end
              smdu_pkg::OP_DIV, smdu_pkg::OP_DIVU,
              smdu_pkg::OP_PDIVW, smdu_pkg::OP_PDIVUW: begin
                if (op_b != 32'd0) begin
                  lo_q[64*cnt_q[0] +: 64] <= {{32{prlo[31]}}, prlo};
                  hi_q[64*cnt_q[0] +: 64] <= {{32{prhi[31]}}, prhi};
                end
              end
              smdu_pkg::OP_PDIVBW: begin
                if (op_b != 32'd0) begin
                  lo_q[32*cnt_q[1:0] +: 32] <= prlo;
                  hi_q[32*cnt_q[1:0] +: 32] <= prhi;
                end
              end
              default: ;
            endcase
            cnt_q   <= cnt_q + 3'd1;
            state_q <= (cnt_q == last_q) ? S_DONE : S_ISSUE;
          end
        end
        S_DONE: begin
          if (!out_valid_q || m_axis_tready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && s_axis_tvalid_i) begin
      op_q   <= in_op;
      a_q    <= s_axis_tdata_i[131:4];
      b_q    <= s_axis_tdata_i[259:132];
      last_q <= in_last;
      dst_q  <= '0;
      mask_q <= 2'b00;
    end else if (state_q == S_WAIT && rsp.done) begin
      case (op_q)
        smdu_pkg::OP_MULT, smdu_pkg::OP_MULTU: begin
          dst_q[63:0] <= {{32{prlo[31]}}, prlo};
          mask_q      <= 2'b01;
        end
        smdu_pkg::OP_PMULTH: begin
          if (!cnt_q[0]) begin
            dst_q[32*cnt_q[2:1] +: 32] <= prlo;
          end
          mask_q <= 2'b11;
        end
        smdu_pkg::OP_PMULTW, smdu_pkg::OP_PMULTUW: begin
          dst_q[64*cnt_q[0] +: 64] <= rsp.res;
          mask_q                   <= 2'b11;
        end
        default: ;
      endcase
    end
    if (state_q == S_DONE && (!out_valid_q || m_axis_tready_i)) begin
      out_q <= {6'd0, hi_q, lo_q, mask_q, dst_q};
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

endmodule

### hw/rtl/smdu_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smdu_mul
// registered 32x32 signed/unsigned multiplier; product and done follow the start in the next cycle
// ----------------------------------------------------------------------------
module smdu_mul (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  smdu_pkg::req_t req_i,
  output smdu_pkg::rsp_t rsp_o
);

  logic        done_q;
  logic [63:0] prod_q;
  logic [65:0] prod;

  assign prod = $signed({req_i.sgn & req_i.a[31], req_i.a})
              * $signed({req_i.sgn & req_i.b[31], req_i.b});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= req_i.start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      prod_q <= prod[63:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = prod_q;

endmodule

### hw/rtl/smdu_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smdu_div
// radix-2 restoring divider, 32 iterations, signed or unsigned
// ----------------------------------------------------------------------------
module smdu_div (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  smdu_pkg::req_t req_i,
  output smdu_pkg::rsp_t rsp_o
);

  logic        busy_q, done_q, nq_q, nr_q;
  logic [4:0]  cnt_q;
  logic [31:0] dvd_q, rem_q, mb_q;
  logic [63:0] res_q;
  logic        na, nb, ge;
  logic [32:0] tmp;
  logic [33:0] diff;
  logic [31:0] qn, rn;

  assign na   = req_i.sgn & req_i.a[31];
  assign nb   = req_i.sgn & req_i.b[31];
  assign tmp  = {rem_q, dvd_q[31]};
  assign diff = {1'b0, tmp} - {2'b00, mb_q};
  assign ge   = ~diff[33];
  assign rn   = ge ? diff[31:0] : tmp[31:0];
  assign qn   = {dvd_q[30:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= na ? (32'd0 - req_i.a) : req_i.a;
      mb_q  <= nb ? (32'd0 - req_i.b) : req_i.b;
      rem_q <= '0;
      nq_q  <= na ^ nb;
      nr_q  <= na;
    end else if (busy_q) begin
      dvd_q <= qn;
      rem_q <= rn;
      if (cnt_q == 5'd31) begin
        res_q <= {nr_q ? (32'd0 - rn) : rn, nq_q ? (32'd0 - qn) : qn};
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule
